### sv/srsg_pkg.sv
// Package for the stepper ramp step generator: widths, command codes,
// sequencer states and shared types. No dependencies.
package srsg_pkg;

  localparam int unsigned PosWidth  = 32;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned QWidth    = 32;
  localparam int unsigned WholeW    = 24;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned DivW      = 64;
  localparam int unsigned DivCntW   = 7;

  localparam logic [QWidth-1:0] QMax      = '1;
  localparam logic [31:0]       IndexMax  = 32'h7FFF_FFFF;
  localparam logic [WholeW-1:0] WholeMax  = '1;
  localparam logic [DivW-1:0]   UsScaled  = DivW'(64'd1000000 << FracBits);

  typedef enum logic [2:0] {
    FUNC_TICK   = 3'd0,
    FUNC_ABS    = 3'd1,
    FUNC_REL    = 3'd2,
    FUNC_STOP   = 3'd3,
    FUNC_SETPOS = 3'd4
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACCEL = 2'd0,
    CFG_FIRST = 2'd1,
    CFG_MIN   = 2'd2,
    CFG_INV   = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SPEED,
    ST_SPEED_W,
    ST_SQUARE,
    ST_STOPD,
    ST_STOPD_W,
    ST_AFTER_ST,
    ST_RAMP,
    ST_DELTA_W,
    ST_FINISH,
    ST_OUT
  } state_e;

  // Request to and answer from the shared divider.
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
  } div_rsp_t;

endpackage

### sv/srsg_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on srsg_pkg.
module srsg_divider
  import srsg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivW-1:0]    rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DivW:0]      trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[DivW-1]};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = DivCntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DivW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d    = DivW'(trial - {1'b0, den_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial[DivW-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

### sv/stepper_ramp_step_generator.sv
// Top level of the stepper ramp step generator: command sequencer, state
// and registers. Depends on srsg_pkg and srsg_divider.
//
// Usage: one request on the input channel (func_i, position_value_i) gives
// exactly one result on the output channel. A tick (func 0) counts one
// microsecond and issues a step when the interval has elapsed; commands move,
// stop or redefine the position. Configuration is written through the
// cfg channel (index 0 accel_rate, 1 first interval, 2 min interval,
// 3 dir_invert) while no request is in flight.
// A request that needs no interval recompute goes from decode straight to the
// output state. A recompute runs the shared 64-bit divider up to three times
// (speed, stopping distance, ramp delta), and a stop command, which first
// finds the stopping distance, runs it more often. The block works on one
// request at a time; in_stall_o is high while a request is processed. The
// next request may be accepted while the previous result still waits, and
// it then holds in its last step until that result is taken. The product
// v*v is one 32x32 multiply, registered.
// Reset clears position, goal, ramp and interval state to zero and loads the
// register reset values. A stalled result holds until taken.
module stepper_ramp_step_generator
  import srsg_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [2:0]               func_i,
  input  logic signed [31:0]       position_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     step_pulse_o,
  output logic                     dir_level_o,
  output logic                     running_o,
  output logic signed [31:0]       position_now_o,
  output logic [WholeW-1:0]        interval_us_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [31:0]              cfg_data_i
);

  state_e state_q, state_d;

  logic [19:0]         accel_q;
  logic [QWidth-1:0]   first_q, min_q;
  logic                inv_q;

  logic [PosWidth-1:0] cur_q, cur_d, goal_q, goal_d;
  logic signed [31:0]  n_q, n_d;
  logic [QWidth-1:0]   iq_q, iq_d;
  logic [WholeW-1:0]   whole_q, whole_d;
  logic                cw_q, cw_d, mov_q, mov_d;
  logic [31:0]         el_q, el_d;

  logic [2:0]          func_q;
  logic [PosWidth-1:0] val_q;
  logic                pulse_q, pulse_d;
  logic                stop_cmd_q, stop_cmd_d;
  logic [31:0]         st_q, st_d;     // stopping distance, saturated
  logic [DivW-1:0]     sq_q, sq_d;     // v*v

  logic                ov_q, ov_d;
  logic                o_pulse_q, o_dir_q, o_run_q;
  logic [31:0]         o_pos_q;
  logic [WholeW-1:0]   o_int_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  srsg_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;

  logic [PosWidth-1:0]        diff;
  logic signed [PosWidth-1:0] dist_go;
  logic [PosWidth:0]          dmag;
  logic [PosWidth-1:0]        target;
  logic signed [33:0]         den4;
  logic [33:0]                den_mag;
  logic [32:0]                q_sum;
  logic [QWidth-1:0]          q_new;
  logic [QWidth-FracBits-1:0] whole_full;
  logic signed [32:0]         n_adj;

  assign diff    = goal_q - cur_q;
  assign dist_go = $signed(diff);
  assign dmag = dist_go[PosWidth-1] ? (PosWidth+1)'(-$signed({dist_go[PosWidth-1], dist_go}))
                                    : {1'b0, diff};

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    goal_d     = goal_q;
    n_d        = n_q;
    iq_d       = iq_q;
    whole_d    = whole_q;
    cw_d       = cw_q;
    mov_d      = mov_q;
    el_d       = el_q;
    pulse_d    = pulse_q;
    stop_cmd_d = stop_cmd_q;
    st_d       = st_q;
    sq_d       = sq_q;
    ov_d       = ov_q;
    div_req    = '0;
    target     = '0;
    den4       = '0;
    den_mag    = '0;
    q_sum      = '0;
    q_new      = '0;
    whole_full = '0;
    n_adj      = '0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          state_d    = ST_DECODE;
          pulse_d    = 1'b0;
          stop_cmd_d = 1'b0;
        end
      end
      ST_DECODE: begin
        state_d = ST_OUT;
        priority case (func_q)
          FUNC_TICK: begin
            if (el_q != 32'hFFFF_FFFF) el_d = el_q + 1'b1;
            if (whole_q != '0 && el_d >= {8'd0, whole_q}) begin
              cur_d   = cw_q ? cur_q + 1'b1 : cur_q - 1'b1;
              el_d    = '0;
              pulse_d = 1'b1;
              state_d = ST_SPEED;
            end
          end
          FUNC_ABS, FUNC_REL: begin
            target = (func_q == FUNC_ABS) ? val_q : cur_q + val_q;
            if (target != goal_q) begin
              goal_d  = target;
              state_d = ST_SPEED;
            end
          end
          FUNC_STOP: begin
            if (mov_q) begin
              stop_cmd_d = 1'b1;
              state_d    = ST_SPEED;
            end
          end
          FUNC_SETPOS: begin
            cur_d   = val_q;
            goal_d  = val_q;
            n_d     = '0;
            whole_d = '0;
            mov_d   = 1'b0;
          end
          default: ;
        endcase
      end
      ST_SPEED: begin
        if (!mov_q) begin
          st_d    = '0;
          state_d = ST_AFTER_ST;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = UsScaled;
          div_req.den   = {32'd0, iq_q};
          state_d       = ST_SPEED_W;
        end
      end
      ST_SPEED_W: begin
        if (div_rsp.done) begin
          if (div_rsp.quot[63:32] != '0) begin
            st_d    = IndexMax;
            state_d = ST_AFTER_ST;
          end else begin
            sq_d    = div_rsp.quot[31:0] * div_rsp.quot[31:0];
            state_d = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        div_req.start = 1'b1;
        div_req.num   = sq_q;
        div_req.den   = {43'd0, accel_q, 1'b0};
        state_d       = ST_STOPD_W;
      end
      ST_STOPD_W: begin
        if (div_rsp.done) begin
          st_d    = (div_rsp.quot > {32'd0, IndexMax}) ? IndexMax : div_rsp.quot[31:0];
          state_d = ST_AFTER_ST;
        end
      end
      ST_AFTER_ST: begin
        if (stop_cmd_q) begin
          stop_cmd_d = 1'b0;
          target = cw_q ? cur_q + PosWidth'(st_q) + 1'b1
                        : cur_q - PosWidth'(st_q) - 1'b1;
          if (target != goal_q) begin
            goal_d  = target;
            state_d = ST_SPEED;
          end else begin
            state_d = ST_OUT;
          end
        end else begin
          state_d = ST_RAMP;
        end
      end
      ST_RAMP: begin
        if (dist_go == '0 && st_q <= 32'd1) begin
          whole_d = '0;
          mov_d   = 1'b0;
          n_d     = '0;
          state_d = ST_OUT;
        end else begin
          n_adj = 33'(n_q);
          // With the goal reached the ramp index is left as it is.
          if (dist_go > 0) begin
            if (n_q > 0) begin
              if ({1'b0, st_q} >= dmag || !cw_q) n_adj = -$signed({1'b0, st_q});
            end else if (n_q < 0) begin
              if ({1'b0, st_q} < dmag && cw_q) n_adj = -33'(n_q);
            end
          end else if (dist_go < 0) begin
            if (n_q > 0) begin
              if ({1'b0, st_q} >= dmag || cw_q) n_adj = -$signed({1'b0, st_q});
            end else if (n_q < 0) begin
              if ({1'b0, st_q} < dmag && !cw_q) n_adj = -33'(n_q);
            end
          end
          n_d = 32'(n_adj);
          if (n_adj == '0) begin
            cw_d    = (dist_go > 0);
            iq_d    = first_q;
            state_d = ST_FINISH;
          end else begin
            den4    = 34'(n_adj) * 34'sd4 + 34'sd1;
            den_mag = den4[33] ? 34'(-den4) : den4;
            div_req.start = 1'b1;
            div_req.num   = {31'd0, iq_q, 1'b0};
            div_req.den   = {30'd0, den_mag};
            state_d       = ST_DELTA_W;
          end
        end
      end
      ST_DELTA_W: begin
        if (div_rsp.done) begin
          if (n_q > 0) begin
            q_sum = {1'b0, iq_q} - 33'(div_rsp.quot);
          end else begin
            q_sum = 33'({1'b0, iq_q}) + 33'(div_rsp.quot);
            if (div_rsp.quot[63:33] != '0 || q_sum[32]) q_sum = {1'b0, QMax};
          end
          q_new   = q_sum[31:0];
          iq_d    = (q_new < min_q) ? min_q : q_new;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (n_q != $signed(IndexMax)) n_d = n_q + 1'b1;
        whole_full = iq_q[QWidth-1:FracBits];
        if (whole_full > WholeMax) whole_d = WholeMax;
        else whole_d = whole_full[WholeW-1:0];
        if (whole_d == '0) whole_d = WholeW'(1);
        mov_d   = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      accel_q <= 20'd1000;
      first_q <= 32'd7739136;
      min_q   <= 32'd256000;
      inv_q   <= 1'b0;
      cur_q   <= '0;
      goal_q  <= '0;
      n_q     <= '0;
      iq_q    <= '0;
      whole_q <= '0;
      cw_q    <= 1'b0;
      mov_q   <= 1'b0;
      el_q    <= '0;
      ov_q    <= 1'b0;
      stop_cmd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      goal_q  <= goal_d;
      n_q     <= n_d;
      iq_q    <= iq_d;
      whole_q <= whole_d;
      cw_q    <= cw_d;
      mov_q   <= mov_d;
      el_q    <= el_d;
      ov_q    <= ov_d;
      stop_cmd_q <= stop_cmd_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_ACCEL: accel_q <= (cfg_data_i[19:0] == '0) ? 20'd1 : cfg_data_i[19:0];
          CFG_FIRST: first_q <= (cfg_data_i == '0) ? 32'd1 : cfg_data_i;
          CFG_MIN:   min_q   <= (cfg_data_i == '0) ? 32'd1 : cfg_data_i;
          CFG_INV:   inv_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pulse_q <= pulse_d;
    st_q    <= st_d;
    sq_q    <= sq_d;
    if (state_q == ST_IDLE && in_valid_i && !in_stall_o) begin
      func_q <= func_i;
      val_q  <= position_value_i;
    end
    if (state_q == ST_OUT && (!ov_q || !out_stall_i)) begin
      o_pulse_q <= pulse_q;
      o_dir_q   <= cw_q ^ inv_q;
      o_run_q   <= mov_q || (goal_q != cur_q);
      o_pos_q   <= cur_q;
      o_int_q   <= whole_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign step_pulse_o   = o_pulse_q;
  assign dir_level_o    = o_dir_q;
  assign running_o      = o_run_q;
  assign position_now_o = o_pos_q;
  assign interval_us_o  = o_int_q;

endmodule

### sv/srsg_checker.sv
// Port-level checker for the stepper ramp step generator, bound to the top.
// Depends on srsg_pkg.
module srsg_checker
  import srsg_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              step_pulse_o,
  input logic [WholeW-1:0] interval_us_o,
  input logic              running_o,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(interval_us_o))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while busy");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |-> in_stall_o)
    else $error("config write raced a request");

  a_step_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && step_pulse_o && running_o |-> interval_us_o != '0)
    else $error("moving step with zero interval");

endmodule

bind stepper_ramp_step_generator srsg_checker u_srsg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .step_pulse_o  (step_pulse_o),
  .interval_us_o (interval_us_o),
  .running_o     (running_o),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);

### dv/stepper_ramp_step_generator_test.sv
// Self-checking testbench for stepper_ramp_step_generator: random and directed
// move, stop, set-position and tick requests are checked against a motion predictor.
// Depends on srsg_pkg and the RTL of the block.
module stepper_ramp_step_generator_test;
  import srsg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint IdxLimit = 64'h7FFF_FFFF;
  localparam logic [2:0] FuncSpareLo = 3'd5;
  localparam logic [2:0] FuncSpareHi = 3'd7;
  localparam int SettleCycles = 300;

  typedef struct {
    logic [2:0]  func;
    logic [31:0] value;
  } motion_req_t;

  typedef struct {
    logic              pulse;
    logic              dir;
    logic              run;
    logic [31:0]       pos;
    logic [WholeW-1:0] ivl;
  } motion_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] func_i = '0;
  logic signed [31:0] position_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic step_pulse_o, dir_level_o, running_o;
  logic signed [31:0] position_now_o;
  logic [WholeW-1:0] interval_us_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_ACCEL;
  logic [31:0] cfg_data_i = '0;

  stepper_ramp_step_generator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor configuration and motion state.
  bit [19:0]  accel;
  bit [31:0]  first_q, min_q;
  bit         dir_inv;
  bit [31:0]  cur_pos, goal_pos, ivl_q, elapsed;
  int         ramp_n;
  bit [23:0]  whole_iv;
  bit         dir_cw, moving;

  motion_req_t pending_reqs[$];
  motion_res_t awaited_results[$];
  int n_presented = 0, n_accepted = 0, errors = 0;
  bit quiet = 0, hold = 0;

  function automatic longint goal_distance();
    int diff;
    diff = goal_pos - cur_pos;
    return longint'(diff);
  endfunction

  function automatic longint stop_distance();
    bit [63:0] c, v, s;
    if (!moving) return 0;
    c = (ivl_q != 0) ? 64'(ivl_q) : 64'd1;
    v = UsScaled / c;
    if (v > 64'hFFFF_FFFF) return IdxLimit;
    s = (v * v) / (64'(accel) * 2);
    return (s > 64'(IdxLimit)) ? IdxLimit : longint'(s);
  endfunction

  function automatic void retime_interval();
    longint d, st, n, den;
    bit [63:0] mag, delta, q, whole;
    d = goal_distance();
    st = stop_distance();
    n = ramp_n;
    if (d == 0 && st <= 1) begin
      whole_iv = 0;
      moving = 0;
      ramp_n = 0;
      return;
    end
    // Turn into deceleration when the stopping distance covers what is left
    // or the motor runs the wrong way; resume acceleration otherwise.
    if (d > 0) begin
      if (n > 0) begin
        if (st >= d || !dir_cw) n = -st;
      end else if (n < 0) begin
        if (st < d && dir_cw) n = -n;
      end
    end else if (d < 0) begin
      if (n > 0) begin
        if (st >= -d || dir_cw) n = -st;
      end else if (n < 0) begin
        if (st < -d && !dir_cw) n = -n;
      end
    end
    if (n == 0) begin
      q = 64'(first_q);
      dir_cw = (d > 0);
    end else begin
      den = 4 * n + 1;
      mag = (den < 0) ? -den : den;
      delta = (64'(ivl_q) << 1) / mag;
      if (den > 0) begin
        q = 64'(ivl_q) - delta;
      end else begin
        q = 64'(ivl_q) + delta;
        if (q > 64'(QMax)) q = 64'(QMax);
      end
      if (q < 64'(min_q)) q = 64'(min_q);
    end
    if (n < IdxLimit) n++;
    ramp_n = int'(n);
    ivl_q = q[31:0];
    whole = q >> FracBits;
    if (whole > 64'(WholeMax)) whole = 64'(WholeMax);
    if (whole == 0) whole = 1;
    whole_iv = whole[23:0];
    moving = 1;
  endfunction

  function automatic void move_goal(bit [31:0] target);
    if (target != goal_pos) begin
      goal_pos = target;
      retime_interval();
    end
  endfunction

  function automatic motion_res_t next_motion_result(motion_req_t r);
    motion_res_t res;
    bit [31:0] st;
    res.pulse = 0;
    case (r.func)
      FUNC_TICK: begin
        if (elapsed != 32'hFFFF_FFFF) elapsed++;
        if (whole_iv != 0 && elapsed >= 32'(whole_iv)) begin
          cur_pos = dir_cw ? cur_pos + 1 : cur_pos - 1;
          elapsed = 0;
          res.pulse = 1;
          retime_interval();
        end
      end
      FUNC_ABS: move_goal(r.value);
      FUNC_REL: move_goal(cur_pos + r.value);
      FUNC_STOP: begin
        if (moving) begin
          st = 32'(stop_distance() + 1);
          move_goal(dir_cw ? cur_pos + st : cur_pos - st);
        end
      end
      FUNC_SETPOS: begin
        cur_pos = r.value;
        goal_pos = r.value;
        ramp_n = 0;
        whole_iv = 0;
        moving = 0;
      end
      default: ;
    endcase
    res.dir = dir_cw ^ dir_inv;
    res.run = moving || (goal_pos != cur_pos);
    res.pos = cur_pos;
    res.ivl = whole_iv;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Request driver: a request stays on the bus until it is taken.
  always @(negedge clk_i) begin
    motion_req_t r;
    if (!in_valid_i || n_accepted == n_presented) begin
      if (rst_ni && pending_reqs.size() > 0 && !hold && (quiet || $urandom_range(99) >= 38)) begin
        r = pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        func_i <= r.func;
        position_value_i <= r.value;
        n_presented++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 38);
  end

  // Monitor: predicts on acceptance and checks each result in order.
  always @(posedge clk_i) begin
    motion_req_t r;
    motion_res_t w;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        r.func = func_i;
        r.value = position_value_i;
        awaited_results.push_back(next_motion_result(r));
        n_accepted++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $display("result with no request outstanding at %0t", $realtime);
          errors++;
        end else begin
          w = awaited_results.pop_front();
          if (step_pulse_o !== w.pulse) report_mismatch("step_pulse", step_pulse_o, w.pulse);
          if (dir_level_o !== w.dir) report_mismatch("dir_level", dir_level_o, w.dir);
          if (running_o !== w.run) report_mismatch("running", running_o, w.run);
          if (position_now_o !== w.pos) report_mismatch("position_now", position_now_o, w.pos);
          if (interval_us_o !== w.ivl) report_mismatch("interval_us", interval_us_o, w.ivl);
        end
      end
    end
  end

  task automatic add_req(logic [2:0] f, logic [31:0] v);
    motion_req_t r;
    r.func = f;
    r.value = v;
    pending_reqs.push_back(r);
  endtask

  task automatic add_ticks(int k);
    repeat (k) add_req(FUNC_TICK, $urandom);
  endtask

  task automatic wait_idle();
    wait (pending_reqs.size() == 0 && n_accepted == n_presented && !in_valid_i &&
          awaited_results.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ACCEL: accel = (data[19:0] == 0) ? 20'd1 : data[19:0];
      CFG_FIRST: first_q = (data == 0) ? 32'd1 : data;
      CFG_MIN:   min_q = (data == 0) ? 32'd1 : data;
      default:   dir_inv = data[0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_profile(logic [31:0] a, logic [31:0] f, logic [31:0] m, logic inv);
    wait_idle();
    write_reg(CFG_ACCEL, a);
    write_reg(CFG_FIRST, f);
    write_reg(CFG_MIN, m);
    write_reg(CFG_INV, 32'(inv));
  endtask

  // Mostly well-formed moves followed by ticks, with stops, reversals and noise.
  task automatic random_traffic(int n);
    int left, k, sel;
    logic [31:0] d;
    left = n;
    while (left > 0) begin
      sel = $urandom_range(99);
      k = $urandom_range(5, 80);
      d = $urandom_range(1, 40);
      if ($urandom_range(1)) d = -d;
      if (sel < 50) begin
        add_req(FUNC_REL, d);
        add_ticks(k);
      end else if (sel < 60) begin
        add_req(FUNC_ABS, $urandom);
        add_ticks(k);
        add_req(FUNC_STOP, $urandom);
        add_ticks(40);
        k += 42;
      end else if (sel < 70) begin
        add_req(FUNC_REL, d);
        add_ticks(k / 4);
        add_req(FUNC_STOP, $urandom);
        add_ticks(k);
        k += k / 4 + 2;
      end else if (sel < 78) begin
        add_req(FUNC_REL, 32'd30);
        add_ticks(15);
        add_req(FUNC_REL, -32'sd60);
        add_ticks(k);
        k += 17;
      end else if (sel < 84) begin
        add_req(FUNC_SETPOS, $urandom);
        add_ticks(3);
        k = 4;
      end else if (sel < 88) begin
        add_req(3'($urandom_range(FuncSpareHi, FuncSpareLo)), $urandom);
        k = 1;
      end else if (sel < 92) begin
        add_req(FUNC_ABS, $urandom);
        add_req(FUNC_REL, $urandom);
        k = 2;
      end else begin
        add_ticks(k);
      end
      left -= k;
    end
  endtask

  initial begin
    accel = 20'd1000;
    first_q = 32'd7739136;
    min_q = 32'd256000;
    dir_inv = 0;
    cur_pos = 0;
    goal_pos = 0;
    ivl_q = 0;
    elapsed = 0;
    ramp_n = 0;
    whole_iv = 0;
    dir_cw = 0;
    moving = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests at the reset profile.
    add_req(FUNC_STOP, 32'd0);
    add_req(FUNC_ABS, 32'd0);
    add_req(FUNC_REL, 32'd0);
    add_req(FuncSpareLo, 32'hFFFF_FFFF);
    add_req(3'd6, 32'h5555_5555);
    add_req(FuncSpareHi, 32'hAAAA_AAAA);
    add_req(FUNC_SETPOS, 32'h7FFF_FFFF);
    add_req(FUNC_REL, 32'd1);
    add_ticks(3);
    add_req(FUNC_STOP, 32'd0);
    add_req(FUNC_SETPOS, 32'h8000_0000);
    add_req(FUNC_ABS, 32'h7FFF_FFFF);
    add_req(FUNC_ABS, 32'h7FFF_FFFF);
    add_req(FUNC_REL, 32'h8000_0000);
    add_req(FUNC_SETPOS, 32'hFFFF_FFFF);
    add_req(FUNC_STOP, 32'd0);
    add_req(FUNC_TICK, 32'hFFFF_FFFF);

    // Fast ramp, inverted direction; an idle wait before a move steps at once.
    set_profile(32'd1000000, 32'd768, 32'd256, 1'b1);
    add_req(FUNC_SETPOS, 32'd0);
    add_ticks(10);
    add_req(FUNC_REL, 32'd5);
    add_ticks(30);
    random_traffic(300);

    // Weakest acceleration and sub-microsecond minimum.
    set_profile(32'd1, 32'd512, 32'd1, 1'b0);
    quiet = 1;
    random_traffic(200);
    wait (pending_reqs.size() == 0);
    quiet = 0;

    // Zero writes store one; then the largest intervals.
    set_profile(32'd0, 32'd0, 32'd0, 1'b1);
    random_traffic(60);
    set_profile(32'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_req(FUNC_REL, 32'd3);
    add_ticks(4);
    add_req(FUNC_STOP, 32'd0);
    add_req(FUNC_SETPOS, 32'd0);

    repeat (4) begin
      set_profile($urandom_range(1000000, 1), $urandom_range(2047, 256),
                  $urandom_range(300, 1), 1'($urandom_range(1)));
      random_traffic(150);
      // Hold the sender until the block has answered everything.
      wait (pending_reqs.size() < 60);
      hold = 1;
      wait (n_accepted == n_presented && awaited_results.size() == 0);
      hold = 0;
      random_traffic(100);
    end

    wait_idle();
    if (errors == 0) begin
      $display("[stepper_ramp_step_generator] OK");
    end else begin
      $display("[stepper_ramp_step_generator] ERROR");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("timeout at %0t", $realtime);
    $display("[stepper_ramp_step_generator] ERROR");
    $finish;
  end

endmodule
